// ----- rtl/mfhd_pkg.sv -----
// Shared types, codes and constants of the MQTT fixed header deframer.
package mfhd_pkg;

   localparam int KIND_W   = 8;
   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 28;
   localparam int TOTAL_W  = 29;
   localparam int COUNT_W  = 3;
   localparam int ERR_W    = 2;
   localparam int CSR_W    = 32;
   localparam int ADDR_W   = 3;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [TOTAL_W-1:0] SIZE_SLACK        = 29'h0001_0000;
   localparam logic [TOTAL_W-1:0] FIRST_LIMIT_RESET = 29'h0001_0000;
   localparam logic [LEN_W-1:0]   MAX_SIZE_RESET    = '0;
   localparam logic [COUNT_W-1:0] LEN_BYTES_MAX     = 3'd4;

   // Register indexes, taken from paddr[2].
   localparam logic REG_MAX_MESSAGE_SIZE  = 1'b0;
   localparam logic REG_FIRST_FRAME_LIMIT = 1'b1;

   localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
   localparam logic [ERR_W-1:0] ERR_LEN_LONG  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_TOO_BIG   = 2'd2;
   localparam logic [ERR_W-1:0] ERR_FIRST_BIG = 2'd3;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_LEN    = 2'd1,
      PH_PAY    = 2'd2,
      PH_CLOSED = 2'd3
   } phase_type;

   typedef struct packed {
      logic [KIND_W-1:0]  frame_kind;
      logic [BYTE_W-1:0]  data_byte;
      logic               has_data;
      logic               frame_first;
      logic               frame_last;
      logic [TOTAL_W-1:0] total_length;
      logic [ERR_W-1:0]   error_code;
   } result_type;

   typedef struct packed {
      logic      push;
      phase_type phase;
   } front_status_type;

endpackage

// ----- rtl/mfhd_front.sv -----
// Front end: parses the byte stream and turns payload bytes, empty frames and errors into result records.
module mfhd_front
   import mfhd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [BYTE_W-1:0]   in_byte,
   input  logic [LEN_W-1:0]    max_message_size,
   input  logic [TOTAL_W-1:0]  first_frame_limit,
   output front_status_type    status,
   output result_type          record
);

   phase_type          phase_ff, phase_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [LEN_W-1:0]   acc_ff, acc_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [LEN_W-1:0]   remain_ff, remain_in;
   logic               started_ff, started_in;
   logic               past_first_ff, past_first_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   logic [LEN_W-1:0]   len_acc;
   logic [COUNT_W-1:0] len_count;
   logic [TOTAL_W-1:0] len_total;
   logic [TOTAL_W-1:0] size_limit;
   logic               too_big;
   logic               first_big;
   logic               push;

   // Seven value bits per length byte, least significant group first.
   always_comb begin
      unique case (count_ff[1:0])
         2'd0:    len_acc = acc_ff | {21'd0, in_byte[6:0]};
         2'd1:    len_acc = acc_ff | {14'd0, in_byte[6:0], 7'd0};
         2'd2:    len_acc = acc_ff | {7'd0, in_byte[6:0], 14'd0};
         default: len_acc = acc_ff | {in_byte[6:0], 21'd0};
      endcase
   end

   assign len_count  = count_ff + 3'd1;
   assign len_total  = {1'b0, len_acc} + TOTAL_W'(1) + {{(TOTAL_W-COUNT_W){1'b0}}, len_count};
   assign size_limit = {1'b0, max_message_size} + SIZE_SLACK;
   assign too_big    = (max_message_size != '0) && !(len_total < size_limit);
   assign first_big  = !(len_total < first_frame_limit);

   always_comb begin
      phase_in      = phase_ff;
      kind_in       = kind_ff;
      acc_in        = acc_ff;
      count_in      = count_ff;
      remain_in     = remain_ff;
      started_in    = started_ff;
      past_first_in = past_first_ff;
      total_in      = total_ff;
      push          = 1'b0;

      record.frame_kind   = kind_ff;
      record.data_byte    = '0;
      record.has_data     = 1'b0;
      record.frame_first  = 1'b0;
      record.frame_last   = 1'b0;
      record.total_length = '0;
      record.error_code   = ERR_NONE;

      if (accept) begin
         unique case (phase_ff)
            PH_IDLE: begin
               kind_in    = in_byte;
               acc_in     = '0;
               count_in   = '0;
               remain_in  = '0;
               started_in = 1'b0;
               phase_in   = PH_LEN;
            end
            PH_LEN: begin
               acc_in   = len_acc;
               count_in = len_count;
               total_in = len_total;
               if (in_byte[7]) begin
                  if (len_count >= LEN_BYTES_MAX) begin
                     phase_in          = PH_CLOSED;
                     push              = 1'b1;
                     record.error_code = ERR_LEN_LONG;
                  end
               end else if (past_first_ff ? too_big : first_big) begin
                  phase_in            = PH_CLOSED;
                  push                = 1'b1;
                  record.total_length = len_total;
                  record.error_code   = past_first_ff ? ERR_TOO_BIG : ERR_FIRST_BIG;
               end else if (len_acc == '0) begin
                  phase_in            = PH_IDLE;
                  past_first_in       = 1'b1;
                  push                = 1'b1;
                  record.frame_first  = 1'b1;
                  record.frame_last   = 1'b1;
                  record.total_length = len_total;
               end else begin
                  remain_in  = len_acc;
                  started_in = 1'b0;
                  phase_in   = PH_PAY;
               end
            end
            PH_PAY: begin
               push                = 1'b1;
               record.data_byte    = in_byte;
               record.has_data     = 1'b1;
               record.frame_first  = !started_ff;
               record.frame_last   = (remain_ff <= LEN_W'(1));
               record.total_length = total_ff;
               started_in          = 1'b1;
               if (remain_ff <= LEN_W'(1)) begin
                  remain_in     = '0;
                  phase_in      = PH_IDLE;
                  past_first_in = 1'b1;
               end else begin
                  remain_in = remain_ff - LEN_W'(1);
               end
            end
            default: begin
               // Closed: bytes are swallowed until reset.
            end
         endcase
      end
   end

   assign status.push  = push;
   assign status.phase = phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         count_ff      <= '0;
         started_ff    <= 1'b0;
         past_first_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         started_ff    <= started_in;
         past_first_ff <= past_first_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      acc_ff    <= acc_in;
      remain_ff <= remain_in;
      total_ff  <= total_in;
   end

endmodule

// ----- rtl/mfhd_queue.sv -----
// Short queue of result records between the parser and the output stage.
module mfhd_queue
   import mfhd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  result_type                   push_data,
   input  logic                         pop,
   output logic                         not_empty,
   output logic                         full,
   output logic [$clog2(DEPTH+1)-1:0]   count,
   output result_type                   head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);

   result_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign do_push = push && (count_ff != CNT_W'(DEPTH));
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign count     = count_ff;

endmodule

// ----- rtl/mfhd_back.sv -----
// Back end: output register that drains the queue onto the result channel.
module mfhd_back
   import mfhd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_not_empty,
   input  result_type q_head,
   output logic       q_pop,
   input  logic       rsp_stall,
   output logic       rsp_valid,
   output result_type rsp_data
);

   logic       valid_ff, valid_in;
   result_type data_ff;
   logic       load;

   // Refill whenever the register is empty or its beat is taken this cycle.
   assign load     = q_not_empty && (!valid_ff || !rsp_stall);
   assign q_pop    = load;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= q_head;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ----- rtl/mqtt_fixed_header_deframer.sv -----
// MQTT fixed header deframer: one stream byte per beat in, at most one result per byte out.
// Throughput: one byte per cycle while req_stall is low; the parser handles each byte combinationally.
// A result is registered in the queue and then in the output register before it is offered
// on the result channel, where rsp_stall can hold it.
// req_stall rises only while the result queue is full, i.e. when the output side stalls.
// Reset (synchronous, active high) returns the parser to waiting for a command byte,
// empties the queue and output register, and reloads the two limit registers.
module mqtt_fixed_header_deframer
   import mfhd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic [BYTE_W-1:0]   req_in_byte,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [KIND_W-1:0]   rsp_frame_kind,
   output logic [BYTE_W-1:0]   rsp_data_byte,
   output logic                rsp_has_data,
   output logic                rsp_frame_first,
   output logic                rsp_frame_last,
   output logic [TOTAL_W-1:0]  rsp_total_length,
   output logic [ERR_W-1:0]    rsp_error_code,

   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [CSR_W-1:0]    pwdata,
   output logic [CSR_W-1:0]    prdata,
   output logic                pready
);

   logic [LEN_W-1:0]   max_size_ff;
   logic [TOTAL_W-1:0] first_limit_ff;
   logic               csr_write;

   front_status_type   front_status;
   result_type         front_record;
   logic               req_accept;

   logic                             q_not_empty;
   logic                             q_full;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
   result_type                       q_head;
   logic                             q_pop;
   result_type                       rsp_data;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff    <= MAX_SIZE_RESET;
         first_limit_ff <= FIRST_LIMIT_RESET;
      end else if (csr_write) begin
         unique case (paddr[2])
            REG_MAX_MESSAGE_SIZE:  max_size_ff    <= pwdata[LEN_W-1:0];
            REG_FIRST_FRAME_LIMIT: first_limit_ff <= pwdata[TOTAL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_MAX_MESSAGE_SIZE:  prdata = {{(CSR_W-LEN_W){1'b0}}, max_size_ff};
         REG_FIRST_FRAME_LIMIT: prdata = {{(CSR_W-TOTAL_W){1'b0}}, first_limit_ff};
         default:               prdata = '0;
      endcase
   end

   assign req_stall  = q_full;
   assign req_accept = req_valid && !req_stall;

   mfhd_front u_front (
      .clock             (clock),
      .reset             (reset),
      .accept            (req_accept),
      .in_byte           (req_in_byte),
      .max_message_size  (max_size_ff),
      .first_frame_limit (first_limit_ff),
      .status            (front_status),
      .record            (front_record)
   );

   mfhd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_status.push),
      .push_data (front_record),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .full      (q_full),
      .count     (q_count),
      .head      (q_head)
   );

   mfhd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

   assign rsp_frame_kind   = rsp_data.frame_kind;
   assign rsp_data_byte    = rsp_data.data_byte;
   assign rsp_has_data     = rsp_data.has_data;
   assign rsp_frame_first  = rsp_data.frame_first;
   assign rsp_frame_last   = rsp_data.frame_last;
   assign rsp_total_length = rsp_data.total_length;
   assign rsp_error_code   = rsp_data.error_code;

   // Once closed, the parser never produces another record.
   assert property (@(posedge clock) disable iff (reset)
      (front_status.phase == PH_CLOSED) |-> !front_status.push)
      else $error("record pushed after the stream was closed");

   // An error record always closes the stream.
   assert property (@(posedge clock) disable iff (reset)
      (front_status.push && (front_record.error_code != ERR_NONE))
         |=> (front_status.phase == PH_CLOSED))
      else $error("error reported but parser did not close");

   // A record is never offered to a full queue.
   assert property (@(posedge clock) disable iff (reset)
      front_status.push |-> !q_full)
      else $error("record pushed into a full queue");

   // Queue occupancy stays within its depth.
   assert property (@(posedge clock) disable iff (reset)
      q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

endmodule
